@@ rtl/plid_pkg.sv @@
// plid_pkg: shared types and codes for the positional list core
// holds request and status codes and the per-cell control struct
// no dependencies
package plid_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 5;
    localparam int COUNT_W      = 5;
    localparam int PLID_CAPACITY = 16;
    localparam int CAPACITY_MAX = 256;
    localparam int FILL_W       = $clog2(CAPACITY_MAX + 1);

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_LOCATE = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic [POS_W-1:0]         pos;
        logic [FILL_W-1:0]        fill;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

@@ rtl/plid_cell.sv @@
// plid_cell: one list slot of the shift chain
// holds one entry, shifts from either neighbor, registers an equality match
// depends on plid_pkg
module plid_cell #(
    parameter int IDX = 0
) (
    input  logic                              i_clk,
    input  plid_pkg::t_cell_ctl               i_ctl,
    input  logic signed [plid_pkg::DATA_W-1:0] i_left,
    input  logic signed [plid_pkg::DATA_W-1:0] i_right,
    output logic signed [plid_pkg::DATA_W-1:0] o_entry,
    output logic                              o_match
);
    import plid_pkg::*;

    localparam int HERE = IDX + 1;

    logic signed [DATA_W-1:0] r_entry;
    logic signed [DATA_W-1:0] n_entry;
    logic                     r_match;
    logic                     n_match;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (int'(i_ctl.pos) == HERE) begin
                n_entry = i_ctl.value;
            end else if (int'(i_ctl.pos) < HERE) begin
                n_entry = i_left;
            end
        end else if (i_ctl.del) begin
            if (int'(i_ctl.pos) <= HERE) begin
                n_entry = i_right;
            end
        end
        n_match = (r_entry == i_ctl.value) && (int'(i_ctl.fill) > IDX);
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_match <= n_match;
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

@@ rtl/positional_list_insert_delete_core.sv @@
// Bounded ordered list of signed 32-bit words kept in a row of shift cells.
// Input channel (i_in_valid / o_in_stall) carries action, position and value;
// output channel (o_out_valid / i_out_stall) returns status, result value and
// the list length after the request. Every request gives exactly one result.
// Insert, delete and clear act at the accepting edge: cells from the position
// up shift for an insert or delete; the result enters the output register.
// For a locate the cells register their compares at the
// accepting edge, the first match is encoded in the next cycle, and the
// input is stalled during that cycle. Requests are taken at one per
// cycle unless the receiver stalls or a locate's match is being encoded.
// The output register is refilled on the same edge it is drained, so a
// waiting result does not block the next request unless the receiver stalls;
// while o_out_valid is high and i_out_stall is high, o_in_stall is high.
// Reset empties the list and drops any pending result; entry storage has no
// reset and slots above the length are never read.
// Depends on plid_pkg and plid_cell.
module positional_list_insert_delete_core #(
    parameter int CAPACITY = plid_pkg::PLID_CAPACITY
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_action,
    input  logic [plid_pkg::POS_W-1:0]          i_position,
    input  logic signed [plid_pkg::DATA_W-1:0]  i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_status,
    output logic signed [plid_pkg::DATA_W-1:0]  o_result_value,
    output logic [plid_pkg::COUNT_W-1:0]        o_count
);
    import plid_pkg::*;

    localparam int FW = $clog2(CAPACITY + 1);
    localparam int CW = ((FW > POS_W) ? FW : POS_W) + 1;

    logic [FW-1:0]            r_fill;
    logic [FW-1:0]            n_fill;
    logic                     r_busy;
    logic                     n_busy;
    logic                     r_out_valid;
    logic [1:0]               r_status;
    logic signed [DATA_W-1:0] r_result;
    logic [COUNT_W-1:0]       r_count;

    logic                     in_xfer;
    logic                     out_xfer;
    logic [CW-1:0]            pos_x;
    logic [CW-1:0]            fill_x;
    t_cell_ctl                ctl;
    logic [1:0]               acc_status;
    logic signed [DATA_W-1:0] acc_result;
    logic signed [DATA_W-1:0] del_val;
    logic signed [DATA_W-1:0] loc_res;
    logic [CAPACITY-1:0]      match;
    logic [CAPACITY-1:0]      first;

    logic signed [DATA_W-1:0] w_entry [CAPACITY];

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [DATA_W-1:0] left;
            logic signed [DATA_W-1:0] right;
            if (g == 0) begin : g_lo
                assign left = '0;
            end else begin : g_lo
                assign left = w_entry[g-1];
            end
            if (g == CAPACITY - 1) begin : g_hi
                assign right = '0;
            end else begin : g_hi
                assign right = w_entry[g+1];
            end
            plid_cell #(
                .IDX(g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (ctl),
                .i_left  (left),
                .i_right (right),
                .o_entry (w_entry[g]),
                .o_match (match[g])
            );
        end
    endgenerate

    assign o_in_stall = r_busy || (r_out_valid && i_out_stall);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_xfer   = r_out_valid && !i_out_stall;
    assign pos_x      = CW'(i_position);
    assign fill_x     = CW'(r_fill);

    // deleted entry select
    always_comb begin
        del_val = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (pos_x == CW'(i + 1)) begin
                del_val = del_val | w_entry[i];
            end
        end
    end

    // first match, then its 1-based position
    assign first = match & (~match + CAPACITY'(1));

    always_comb begin
        loc_res = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (first[i]) begin
                loc_res = loc_res | DATA_W'(i + 1);
            end
        end
    end

    always_comb begin
        ctl.ins    = 1'b0;
        ctl.del    = 1'b0;
        ctl.pos    = i_position;
        ctl.fill   = FILL_W'(r_fill);
        ctl.value  = i_value;
        acc_status = ST_OK;
        acc_result = '0;
        n_fill     = r_fill;
        n_busy     = 1'b0;
        if (in_xfer) begin
            unique case (i_action)
                ACT_INSERT: begin
                    if (r_fill == FW'(CAPACITY)) begin
                        acc_status = ST_FULL;
                    end else if (pos_x == '0 || pos_x > fill_x + CW'(1)) begin
                        acc_status = ST_BADPOS;
                    end else begin
                        ctl.ins = 1'b1;
                        n_fill  = r_fill + FW'(1);
                    end
                end
                ACT_DELETE: begin
                    if (r_fill == '0) begin
                        acc_status = ST_EMPTY;
                    end else if (pos_x == '0 || pos_x > fill_x) begin
                        acc_status = ST_BADPOS;
                    end else begin
                        ctl.del    = 1'b1;
                        acc_result = del_val;
                        n_fill     = r_fill - FW'(1);
                    end
                end
                ACT_LOCATE: begin
                    n_busy = 1'b1;
                end
                ACT_CLEAR: begin
                    n_fill = '0;
                end
                default: begin
                    n_fill = r_fill;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill <= n_fill;
            r_busy <= n_busy;
            if (r_busy) begin
                r_out_valid <= 1'b1;
            end else if (in_xfer && i_action != ACT_LOCATE) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_status <= ST_OK;
            r_result <= loc_res;
            r_count  <= COUNT_W'(r_fill);
        end else if (in_xfer && i_action != ACT_LOCATE) begin
            r_status <= acc_status;
            r_result <= acc_result;
            r_count  <= COUNT_W'(n_fill);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_result_value = r_result;
    assign o_count        = r_count;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(CAPACITY))
        else $error("list length above capacity");

    a_locate_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> !r_busy && o_out_valid)
        else $error("locate phase did not finish in one cycle");

    a_locate_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_action == ACT_LOCATE) |=> r_busy && $stable(r_fill))
        else $error("locate did not enter its match phase");

    a_full_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_action == ACT_INSERT && r_fill == FW'(CAPACITY))
        |=> (r_fill == $past(r_fill)) && (o_status == ST_FULL))
        else $error("insert into full list changed the list");
`endif

endmodule

@@ tb/testbench.sv @@
// testbench: self-checking bench for positional_list_insert_delete_core
// keeps a shadow copy of the list to predict every reply; needs plid_pkg and the core rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import plid_pkg::*;

    localparam int LIST_DEPTH     = PLID_CAPACITY;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] value;
        logic [COUNT_W-1:0]       count;
    } t_list_reply;

    logic                     i_clk          = 1'b0;
    logic                     i_rst_n        = 1'b0;
    logic                     i_in_valid     = 1'b0;
    logic                     o_in_stall;
    logic [1:0]               i_action       = ACT_CLEAR;
    logic [POS_W-1:0]         i_position     = '0;
    logic signed [DATA_W-1:0] i_value        = '0;
    logic                     o_out_valid;
    logic                     i_out_stall    = 1'b0;
    logic [1:0]               o_status;
    logic signed [DATA_W-1:0] o_result_value;
    logic [COUNT_W-1:0]       o_count;

    logic signed [DATA_W-1:0] shadow_list [LIST_DEPTH];
    int                       shadow_len = 0;
    t_list_reply              pending_replies [$];
    t_list_reply              head_reply;
    int                       error_count = 0;
    int                       quiet_cycles = 0;
    int                       burst_left = 0;
    int                       stall_mode = 0;
    int                       stall_mode_left = 0;
    int                       cycle_ctr = 0;

    logic signed [DATA_W-1:0] corner_values [16] = '{
        32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, -32'sd1,
        32'sh5555_5555, 32'shaaaa_aaaa, 32'sd7,         32'sh0000_0001,
        32'shffff_fffe, 32'sd7,         32'sh1234_5678, 32'sh8000_0001,
        32'sh7fff_fffe, 32'shdead_beef, 32'sh0f0f_0f0f, 32'shf0f0_f0f0
    };

    positional_list_insert_delete_core #(
        .CAPACITY(LIST_DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_position    (i_position),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_result_value(o_result_value),
        .o_count       (o_count)
    );

    always #6 i_clk = ~i_clk;

    // shadow list update, returns the reply the core owes for this request
    function automatic t_list_reply apply_request(logic [1:0] act, logic [POS_W-1:0] pos,
                                                  logic signed [DATA_W-1:0] val);
        t_list_reply r;
        int          p;
        r.status = ST_OK;
        r.value  = '0;
        p        = int'(pos);
        case (act)
            ACT_INSERT: begin
                if (shadow_len >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else if (p < 1 || p > shadow_len + 1) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (int k = shadow_len; k >= p; k--) shadow_list[k] = shadow_list[k-1];
                    shadow_list[p-1] = val;
                    shadow_len++;
                end
            end
            ACT_DELETE: begin
                if (shadow_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (p < 1 || p > shadow_len) begin
                    r.status = ST_BADPOS;
                end else begin
                    r.value = shadow_list[p-1];
                    for (int k = p; k < shadow_len; k++) shadow_list[k-1] = shadow_list[k];
                    shadow_len--;
                end
            end
            ACT_LOCATE: begin
                for (int k = 0; k < shadow_len; k++) begin
                    if (shadow_list[k] == val) begin
                        r.value = DATA_W'(k + 1);
                        break;
                    end
                end
            end
            default: begin
                shadow_len = 0;
            end
        endcase
        r.count = shadow_len[COUNT_W-1:0];
        return r;
    endfunction

    // one transfer on the request side, then the sender's burst and gap pattern
    task automatic push_request(logic [1:0] act, logic [POS_W-1:0] pos,
                                logic signed [DATA_W-1:0] val);
        int gap;
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_position <= pos;
        i_value    <= val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_replies.push_back(apply_request(act, pos, val));
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            case ($urandom_range(0, 3))
                0: gap = 0;
                1: gap = 1;
                2: gap = $urandom_range(2, 6);
                default: gap = $urandom_range(7, 25);
            endcase
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 160)
                                                      : $urandom_range(1, 40);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // hold off requests until every reply is back
    task automatic settle_list();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_replies.size() != 0);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 1) == 0) return corner_values[$urandom_range(0, 15)];
        return $urandom;
    endfunction

    function automatic logic [POS_W-1:0] pick_position(int hi);
        if (hi >= 1 && $urandom_range(0, 9) != 0) return POS_W'($urandom_range(1, hi));
        return POS_W'($urandom_range(0, 17));
    endfunction

    task automatic test_empty_list();
        push_request(ACT_DELETE, 5'd1, 32'sd0);
        push_request(ACT_LOCATE, 5'd0, 32'sd0);
        push_request(ACT_INSERT, 5'd0, 32'sd3);
        push_request(ACT_INSERT, 5'd2, 32'sd3);
        settle_list();
    endtask

    task automatic test_full_list();
        logic [POS_W-1:0] pos;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            case (i % 3)
                0: pos = 5'd1;
                1: pos = POS_W'(shadow_len + 1);
                default: pos = POS_W'(shadow_len / 2 + 1);
            endcase
            push_request(ACT_INSERT, pos, corner_values[i]);
        end
        push_request(ACT_INSERT, 5'd1, 32'sd99);
        push_request(ACT_LOCATE, 5'd17, 32'sd7);
        push_request(ACT_LOCATE, 5'd0, 32'sd12345);
        push_request(ACT_DELETE, 5'd17, 32'sd0);
        push_request(ACT_DELETE, 5'd0, 32'sd0);
        push_request(ACT_DELETE, 5'd16, 32'sd0);
        push_request(ACT_INSERT, 5'd17, 32'sd1);
        settle_list();
    endtask

    task automatic test_clear();
        push_request(ACT_CLEAR, 5'd31, 32'sh7fff_ffff);
        push_request(ACT_LOCATE, 5'd1, 32'sh8000_0000);
        push_request(ACT_INSERT, 5'd1, 32'sh8000_0000);
        settle_list();
    endtask

    task automatic test_random_traffic(int n_items);
        int                       sent;
        int                       phase_left;
        int                       phase_kind;
        int                       pick;
        int                       ins_cut;
        int                       del_cut;
        int                       loc_cut;
        logic [1:0]               act;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        sent       = 0;
        phase_left = 0;
        phase_kind = 0;
        while (sent < n_items) begin
            if (phase_left == 0) begin
                phase_kind = $urandom_range(0, 2);
                phase_left = $urandom_range(30, 120);
                if ($urandom_range(0, 3) == 0) settle_list();
            end
            case (phase_kind)
                0: begin ins_cut = 55; del_cut = 70; loc_cut = 98; end
                1: begin ins_cut = 20; del_cut = 70; loc_cut = 99; end
                default: begin ins_cut = 35; del_cut = 70; loc_cut = 98; end
            endcase
            pick = $urandom_range(0, 99);
            val  = pick_value();
            if (pick < ins_cut) begin
                act = ACT_INSERT;
                pos = pick_position(shadow_len + 1);
            end else if (pick < del_cut) begin
                act = ACT_DELETE;
                pos = pick_position(shadow_len);
                val = $urandom;
            end else if (pick < loc_cut) begin
                act = ACT_LOCATE;
                pos = POS_W'($urandom_range(0, 17));
                if (shadow_len > 0 && $urandom_range(0, 9) < 7)
                    val = shadow_list[$urandom_range(0, shadow_len - 1)];
            end else begin
                act = ACT_CLEAR;
                pos = POS_W'($urandom_range(0, 17));
            end
            push_request(act, pos, val);
            sent++;
            phase_left--;
        end
        settle_list();
    endtask

    // receiver stall pattern, switching among four styles
    always @(posedge i_clk) begin
        cycle_ctr <= cycle_ctr + 1;
        if (stall_mode_left == 0) begin
            stall_mode      <= $urandom_range(0, 3);
            stall_mode_left <= $urandom_range(20, 200);
        end else begin
            stall_mode_left <= stall_mode_left - 1;
        end
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= cycle_ctr[2];
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_replies.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result: status %0d value %0d count %0d",
                             o_status, o_result_value, o_count);
            end else begin
                head_reply = pending_replies.pop_front();
                if (o_status !== head_reply.status || o_result_value !== head_reply.value ||
                    o_count !== head_reply.count) begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"mismatch: expected status %0d value %0d count %0d, ",
                                  "got status %0d value %0d count %0d"},
                                 head_reply.status, head_reply.value, head_reply.count,
                                 o_status, o_result_value, o_count);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_list();
        test_full_list();
        test_clear();
        test_random_traffic(1200);
        repeat (4) @(posedge i_clk);
        if (error_count == 0 && pending_replies.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
